/* hw/rtl/gate_pattern_step_sequencer_macros.svh */
// Assertion macros shared by the gate pattern step sequencer RTL.
`ifndef GATE_PATTERN_STEP_SEQUENCER_MACROS_SVH
`define GATE_PATTERN_STEP_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define GPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define GPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define GPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* hw/rtl/gps_pkg.sv */
// Package with shared constants and types of the gate pattern step sequencer.
`timescale 1ns / 1ps
`default_nettype none

package gps_pkg;

  // Default geometry of the gate pattern.
  localparam int unsigned ROWS_DEF  = 8;
  localparam int unsigned STEPS_DEF = 16;

  // Fixed widths of the item fields.
  localparam int unsigned PHASE_W    = 24;
  localparam int unsigned STEP_CNT_W = 5;
  localparam int unsigned ROW_IDX_W  = 3;
  localparam int unsigned COL_IDX_W  = 4;
  localparam int unsigned GATE_W     = 8;
  localparam int unsigned CUR_STEP_W = 4;

  // Per-item status from the step controller.
  typedef struct packed {
    logic adv;
    logic running;
  } gps_status_t;

endpackage

`default_nettype wire

/* hw/rtl/gps_ctrl.sv */
// Run flag, phase accumulator and step index update for one item.
`timescale 1ns / 1ps
`default_nettype none

module gps_ctrl import gps_pkg::*; #(
  parameter int unsigned STEPS = STEPS_DEF,
  localparam int unsigned SW = (STEPS > 1) ? $clog2(STEPS) : 1,
  localparam int unsigned CW = SW + 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  accept_i,
  input  wire logic                  run_press_i,
  input  wire logic                  ext_conn_i,
  input  wire logic                  ext_edge_i,
  input  wire logic                  reset_edge_i,
  input  wire logic [PHASE_W-1:0]    phase_step_i,
  input  wire logic [STEP_CNT_W-1:0] step_count_i,
  output logic      [SW-1:0]         step_o,
  output gps_status_t                status_o
);

  logic               run_q, run_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [SW-1:0]      step_q, step_d;
  logic               adv;
  logic [PHASE_W:0]   sum;
  logic [CW-1:0]      inc;
  logic [CW-1:0]      nsteps;

  // Next state of the item: run toggle, clock, reset, then advance.
  always_comb begin
    run_d   = run_q ^ run_press_i;
    phase_d = phase_q;
    step_d  = step_q;
    adv     = 1'b0;
    sum     = {1'b0, phase_q} + {1'b0, phase_step_i};
    inc     = CW'(step_q) + CW'(1);

    // Active step count is clamped to 1..STEPS.
    if (step_count_i == '0) begin
      nsteps = CW'(1);
    end else if (32'(step_count_i) > STEPS) begin
      nsteps = CW'(STEPS);
    end else begin
      nsteps = CW'(step_count_i);
    end

    if (run_d) begin
      if (ext_conn_i) begin
        if (ext_edge_i) begin
          phase_d = '0;
          adv     = 1'b1;
        end
      end else begin
        phase_d = sum[PHASE_W-1:0];
        adv     = sum[PHASE_W];
      end
    end

    if (reset_edge_i) begin
      phase_d = '0;
      adv     = 1'b1;
    end

    if (adv) begin
      if (reset_edge_i || (inc >= nsteps)) begin
        step_d = '0;
      end else begin
        step_d = inc[SW-1:0];
      end
    end
  end

  // State registers, updated once per accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b1;
      phase_q <= '0;
      step_q  <= '0;
    end else if (accept_i) begin
      run_q   <= run_d;
      phase_q <= phase_d;
      step_q  <= step_d;
    end
  end

  assign step_o           = step_d;
  assign status_o.adv     = adv;
  assign status_o.running = run_d;

endmodule

`default_nettype wire

/* hw/rtl/gps_pat_mem.sv */
// Gate pattern memory: one write port, two registered read ports, cleared by valid bits.
`timescale 1ns / 1ps
`default_nettype none

module gps_pat_mem import gps_pkg::*; #(
  parameter int unsigned ROWS  = ROWS_DEF,
  parameter int unsigned STEPS = STEPS_DEF,
  localparam int unsigned SW = (STEPS > 1) ? $clog2(STEPS) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            we_i,
  input  wire logic [SW-1:0]   waddr_i,
  input  wire logic [ROWS-1:0] wdata_i,
  input  wire logic            re_i,
  input  wire logic [SW-1:0]   raddr_a_i,
  input  wire logic [SW-1:0]   raddr_b_i,
  output logic      [ROWS-1:0] rdata_a_o,
  output logic      [ROWS-1:0] rdata_b_o
);

  logic [ROWS-1:0]  mem_q [STEPS];
  logic [STEPS-1:0] vld_q;
  logic [ROWS-1:0]  rd_a_q, rd_b_q;
  logic             rdv_a_q, rdv_b_q;
  logic             byp_a, byp_b;

  // A read that meets a write to the same entry takes the new word.
  assign byp_a = we_i && (waddr_i == raddr_a_i);
  assign byp_b = we_i && (waddr_i == raddr_b_i);

  // Storage array and read data registers.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_a_q <= byp_a ? wdata_i : mem_q[raddr_a_i];
      rd_b_q <= byp_b ? wdata_i : mem_q[raddr_b_i];
    end
  end

  // Entry valid bits; an entry never written reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      rdv_a_q <= 1'b0;
      rdv_b_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rdv_a_q <= vld_q[raddr_a_i] | byp_a;
        rdv_b_q <= vld_q[raddr_b_i] | byp_b;
      end
    end
  end

  assign rdata_a_o = rdv_a_q ? rd_a_q : '0;
  assign rdata_b_o = rdv_b_q ? rd_b_q : '0;

endmodule

`default_nettype wire

/* hw/rtl/gate_pattern_step_sequencer.sv */
// Gate pattern step sequencer: ROWS x STEPS gate pattern clocked by sample ticks.
//
// Each item on the input channel (in_valid_i / in_ready_o) is one sample tick
// carrying run, clock and reset edges, the internal phase increment, the
// active step count and an optional pattern bit toggle. Each item yields
// exactly one result item on the output channel (out_valid_o / out_ready_i):
// the gates of the current step, the step index, the run flag and whether
// the step advanced on that tick.
// Items pass the second stage, then the output register; throughput is one item
// per cycle unless the receiver stalls. The run/phase/step update is done at
// acceptance, the pattern memory is read there, its read-modify-write finishes
// in the second stage, with a read-port write bypass for back-to-back items.
// After reset the pattern reads as all zero (per-entry valid bits), the
// sequencer is running at step 0 with the phase at 0; no clearing pass is
// needed, so items are taken right away.
// When the receiver stalls, the output register holds its item, the second
// stage still takes one more item, and in_ready_o falls only when both are full.
`timescale 1ns / 1ps
`default_nettype none
`include "gate_pattern_step_sequencer_macros.svh"

module gate_pattern_step_sequencer import gps_pkg::*; #(
  parameter int unsigned ROWS  = ROWS_DEF,
  parameter int unsigned STEPS = STEPS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  run_press_i,
  input  wire logic                  ext_clock_connected_i,
  input  wire logic                  ext_clock_edge_i,
  input  wire logic                  reset_edge_i,
  input  wire logic [PHASE_W-1:0]    phase_step_i,
  input  wire logic [STEP_CNT_W-1:0] step_count_i,
  input  wire logic                  toggle_valid_i,
  input  wire logic [ROW_IDX_W-1:0]  toggle_row_i,
  input  wire logic [COL_IDX_W-1:0]  toggle_col_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic      [GATE_W-1:0]     gates_o,
  output logic      [CUR_STEP_W-1:0] current_step_o,
  output logic                       is_running_o,
  output logic                       advanced_o
);

  localparam int unsigned SW = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic            in_fire, s1_fire;
  logic [SW-1:0]   step_new;
  gps_status_t     status;
  logic            tgl_ok;
  logic [SW-1:0]   tgl_addr;
  logic [ROWS-1:0] tgl_mask;
  logic [ROWS-1:0] rd_tgl, rd_step;
  logic [ROWS-1:0] new_word, gate_word;

  // Second stage: item waiting on memory read data.
  logic            s1_v_q;
  logic            s1_adv_q, s1_run_q, s1_tgl_q;
  logic [SW-1:0]   s1_step_q, s1_col_q;
  logic [ROWS-1:0] s1_mask_q;

  // Output register.
  logic                  out_v_q;
  logic [GATE_W-1:0]     gates_q;
  logic [CUR_STEP_W-1:0] cur_step_q;
  logic                  run_out_q, adv_out_q;

  // Handshake: the second stage moves on whenever the output register frees.
  assign s1_fire    = s1_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !s1_v_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  // Step controller.
  gps_ctrl #(
    .STEPS (STEPS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_fire),
    .run_press_i  (run_press_i),
    .ext_conn_i   (ext_clock_connected_i),
    .ext_edge_i   (ext_clock_edge_i),
    .reset_edge_i (reset_edge_i),
    .phase_step_i (phase_step_i),
    .step_count_i (step_count_i),
    .step_o       (step_new),
    .status_o     (status)
  );

  // Toggle decode; a row or column outside the pattern is ignored.
  assign tgl_ok   = toggle_valid_i && (32'(toggle_row_i) < ROWS)
                    && (32'(toggle_col_i) < STEPS);
  assign tgl_addr = SW'(toggle_col_i);
  assign tgl_mask = ROWS'(1) << toggle_row_i;

  // Pattern memory: port A reads the toggled column, port B the new step.
  gps_pat_mem #(
    .ROWS  (ROWS),
    .STEPS (STEPS)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (s1_fire && s1_tgl_q),
    .waddr_i   (s1_col_q),
    .wdata_i   (new_word),
    .re_i      (in_fire),
    .raddr_a_i (tgl_addr),
    .raddr_b_i (step_new),
    .rdata_a_o (rd_tgl),
    .rdata_b_o (rd_step)
  );

  // Modify the column and pick the gates; a same-tick toggle is visible.
  always_comb begin
    new_word = rd_tgl ^ s1_mask_q;
    if (s1_adv_q) begin
      gate_word = '0;
    end else if (s1_tgl_q && (s1_col_q == s1_step_q)) begin
      gate_word = new_word;
    end else begin
      gate_word = rd_step;
    end
  end

  // Second stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_fire) begin
      s1_v_q <= 1'b1;
    end else if (s1_fire) begin
      s1_v_q <= 1'b0;
    end
  end

  // Second stage payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_adv_q  <= status.adv;
      s1_run_q  <= status.running;
      s1_tgl_q  <= tgl_ok;
      s1_step_q <= step_new;
      s1_col_q  <= tgl_addr;
      s1_mask_q <= tgl_mask;
    end
  end

  // Output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s1_fire) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      gates_q    <= GATE_W'(gate_word);
      cur_step_q <= CUR_STEP_W'(s1_step_q);
      run_out_q  <= s1_run_q;
      adv_out_q  <= s1_adv_q;
    end
  end

  assign out_valid_o    = out_v_q;
  assign gates_o        = gates_q;
  assign current_step_o = cur_step_q;
  assign is_running_o   = run_out_q;
  assign advanced_o     = adv_out_q;

  // Checks on the pipeline and the result.
  `GPS_ASSERT_IMP(a_adv_gates_low, clk_i, rst_ni, out_valid_o && advanced_o, gates_o == '0, "gates high on an advance item")
  `GPS_ASSERT_IMP(a_stall_only_full, clk_i, rst_ni, !in_ready_o, s1_v_q && out_v_q, "input stalled with a free stage")
  `GPS_ASSERT_NXT(a_accept_fills, clk_i, rst_ni, in_fire, s1_v_q, "accepted item lost before the second stage")
  `GPS_ASSERT_IMP(a_step_in_range, clk_i, rst_ni, s1_v_q, 32'(s1_step_q) < STEPS, "step index beyond the pattern")

endmodule

`default_nettype wire

/* tb/tb_gate_pattern_step_sequencer.sv */
// Self-checking testbench for the gate pattern step sequencer.
`timescale 1ns / 1ps

module tb_gate_pattern_step_sequencer;
  import gps_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned DRAIN_CYCLES = 10;

  // One sample tick as offered on the input channel.
  typedef struct packed {
    logic                  run_press;
    logic                  ext_conn;
    logic                  ext_edge;
    logic                  reset_edge;
    logic [PHASE_W-1:0]    phase_step;
    logic [STEP_CNT_W-1:0] step_count;
    logic                  toggle_valid;
    logic [ROW_IDX_W-1:0]  toggle_row;
    logic [COL_IDX_W-1:0]  toggle_col;
  } tick_t;

  // One result item from the output channel.
  typedef struct packed {
    logic [GATE_W-1:0]     gates;
    logic [CUR_STEP_W-1:0] step;
    logic                  running;
    logic                  advanced;
  } step_out_t;

  // Tracks sequencer state and checks each output item against its prediction.
  class step_seq_scoreboard;
    logic [GATE_W-1:0]     pattern [STEPS_DEF];
    logic                  running;
    logic [PHASE_W-1:0]    phase;
    logic [CUR_STEP_W-1:0] step;
    step_out_t             expected_q [$];
    int unsigned           mismatches;
    int unsigned           checked;
    int unsigned           advances;
    int unsigned           resets;
    int unsigned           stopped_ticks;

    function new();
      foreach (pattern[i]) pattern[i] = '0;
      running = 1'b1;
      phase   = '0;
      step    = '0;
    endfunction

    // Apply one accepted tick to the state and queue the result it must produce.
    function void note_tick(tick_t t);
      logic [PHASE_W:0]      sum;
      logic [STEP_CNT_W-1:0] active;
      logic [STEP_CNT_W:0]   nxt;
      logic                  adv;
      step_out_t             r;

      adv = 1'b0;
      if (t.run_press) running = !running;
      if (running) begin
        if (t.ext_conn) begin
          if (t.ext_edge) begin
            phase = '0;
            adv   = 1'b1;
          end
        end else begin
          sum   = {1'b0, phase} + {1'b0, t.phase_step};
          adv   = sum[PHASE_W];
          phase = sum[PHASE_W-1:0];
        end
      end else begin
        stopped_ticks++;
      end
      if (t.reset_edge) begin
        phase = '0;
        adv   = 1'b1;
        resets++;
      end
      if (adv) begin
        // Requested count is clamped to 1..STEPS.
        active = t.step_count;
        if (active == 0) active = STEP_CNT_W'(1);
        if (active > STEPS_DEF) active = STEP_CNT_W'(STEPS_DEF);
        nxt = {2'b00, step} + 1'b1;
        if (t.reset_edge || nxt >= active) step = '0;
        else step = nxt[CUR_STEP_W-1:0];
        advances++;
      end
      if (t.toggle_valid) pattern[t.toggle_col][t.toggle_row] ^= 1'b1;

      r.gates    = adv ? '0 : pattern[step];
      r.step     = step;
      r.running  = running;
      r.advanced = adv;
      expected_q.push_back(r);
    endfunction

    task report(string field, int unsigned got, int unsigned want);
      mismatches++;
      if (mismatches <= 30)
        $display("[%0t] error on %s: got 0x%0h, want 0x%0h", $time, field, got, want);
    endtask

    // Compare one output item field by field with the oldest prediction.
    task check_out(step_out_t got);
      step_out_t want;
      if (expected_q.size() == 0) begin
        report("unexpected output item", 32'(got), 0);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.gates !== want.gates)
        report("gates", 32'(got.gates), 32'(want.gates));
      if (got.step !== want.step)
        report("current_step", 32'(got.step), 32'(want.step));
      if (got.running !== want.running)
        report("is_running", 32'(got.running), 32'(want.running));
      if (got.advanced !== want.advanced)
        report("advanced", 32'(got.advanced), 32'(want.advanced));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  out_ready = 1'b0;
  tick_t                 tick_d = '0;
  logic                  in_ready_o;
  logic                  out_valid_o;
  logic [GATE_W-1:0]     gates_o;
  logic [CUR_STEP_W-1:0] current_step_o;
  logic                  is_running_o;
  logic                  advanced_o;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_req = 1'b0;
  int unsigned items_sent = 0;
  int unsigned in_stalls = 0;

  step_seq_scoreboard sb = new();

  gate_pattern_step_sequencer i_dut (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .in_valid_i            (in_valid),
    .in_ready_o            (in_ready_o),
    .run_press_i           (tick_d.run_press),
    .ext_clock_connected_i (tick_d.ext_conn),
    .ext_clock_edge_i      (tick_d.ext_edge),
    .reset_edge_i          (tick_d.reset_edge),
    .phase_step_i          (tick_d.phase_step),
    .step_count_i          (tick_d.step_count),
    .toggle_valid_i        (tick_d.toggle_valid),
    .toggle_row_i          (tick_d.toggle_row),
    .toggle_col_i          (tick_d.toggle_col),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready),
    .gates_o               (gates_o),
    .current_step_o        (current_step_o),
    .is_running_o          (is_running_o),
    .advanced_o            (advanced_o)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watch both channels; predict on input items and check output items.
  always @(posedge clk) begin
    if (in_valid && in_ready_o) sb.note_tick(tick_d);
    if (in_valid && !in_ready_o && rst_n) in_stalls++;
    if (out_valid_o && out_ready)
      sb.check_out({gates_o, current_step_o, is_running_o, advanced_o});
  end

  // Receiver: random stalls, plus a long hold-off whenever hold_req flips.
  initial begin
    logic        hold_seen;
    int unsigned hold_left;
    hold_seen = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // Offer one tick, with random idle cycles ahead of it, and wait for acceptance.
  task automatic send_tick(input tick_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    tick_d   <= t;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    items_sent++;
  endtask

  function automatic tick_t mk_tick(logic run, logic conn, logic ext, logic rst,
                                    logic [PHASE_W-1:0] ph, logic [STEP_CNT_W-1:0] cnt,
                                    logic tv, logic [ROW_IDX_W-1:0] row,
                                    logic [COL_IDX_W-1:0] col);
    tick_t t;
    t.run_press    = run;
    t.ext_conn     = conn;
    t.ext_edge     = ext;
    t.reset_edge   = rst;
    t.phase_step   = ph;
    t.step_count   = cnt;
    t.toggle_valid = tv;
    t.toggle_row   = row;
    t.toggle_col   = col;
    return t;
  endfunction

  // Random tick that keeps the sequencer mostly running and advancing often.
  function automatic tick_t random_tick();
    tick_t       t;
    int unsigned sel;
    t.run_press  = ($urandom_range(99) < 4);
    t.ext_conn   = ($urandom_range(99) < 40);
    t.ext_edge   = ($urandom_range(99) < 35);
    t.reset_edge = ($urandom_range(99) < 4);
    sel = $urandom_range(99);
    if (sel < 40) t.phase_step = PHASE_W'($urandom_range(24'hFFFFFF, 24'h400000));
    else if (sel < 70) t.phase_step = PHASE_W'($urandom());
    else if (sel < 85) t.phase_step = PHASE_W'($urandom_range(16'hFFFF, 0));
    else if (sel < 95) t.phase_step = 24'hFFFFFF;
    else t.phase_step = '0;
    sel = $urandom_range(99);
    if (sel < 60) t.step_count = STEP_CNT_W'($urandom_range(STEPS_DEF, 1));
    else if (sel < 85) t.step_count = STEP_CNT_W'($urandom());
    else t.step_count = STEP_CNT_W'($urandom_range(4, 1));
    t.toggle_valid = ($urandom_range(99) < 50);
    t.toggle_row   = ROW_IDX_W'($urandom());
    t.toggle_col   = COL_IDX_W'($urandom());
    return t;
  endfunction

  // Main sequence: reset, directed ticks, random phases, pressure, drain.
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, clock sources, run toggle and reset corner cases.
    send_tick(mk_tick(0, 0, 0, 0, 24'h000000, 5'd16, 0, 3'd0, 4'd0));
    send_tick(mk_tick(0, 0, 0, 0, 24'h000000, 5'd16, 1, 3'd0, 4'd0));
    send_tick(mk_tick(0, 0, 0, 0, 24'h000000, 5'd16, 1, 3'd7, 4'd0));
    send_tick(mk_tick(0, 0, 0, 0, 24'h000000, 5'd16, 1, 3'd7, 4'd15));
    send_tick(mk_tick(0, 0, 0, 0, 24'hFFFFFF, 5'd16, 0, 3'd0, 4'd0));
    // Smallest step that carries out of the phase.
    send_tick(mk_tick(0, 0, 0, 0, 24'h000001, 5'd16, 1, 3'd2, 4'd1));
    send_tick(mk_tick(0, 0, 0, 0, 24'h800000, 5'd16, 1, 3'd5, 4'd2));
    send_tick(mk_tick(0, 0, 0, 0, 24'h800000, 5'd16, 0, 3'd0, 4'd0));
    // External clock: an edge advances, the phase step is ignored.
    send_tick(mk_tick(0, 1, 1, 0, 24'h000000, 5'd16, 0, 3'd0, 4'd0));
    send_tick(mk_tick(0, 1, 0, 0, 24'hFFFFFF, 5'd16, 1, 3'd4, 4'd3));
    // Count lowered below the current step: the index holds until the next advance.
    send_tick(mk_tick(0, 1, 0, 0, 24'h000000, 5'd2, 0, 3'd0, 4'd0));
    send_tick(mk_tick(0, 1, 1, 0, 24'h000000, 5'd2, 0, 3'd0, 4'd0));
    // A count of zero acts as one; above STEPS acts as STEPS.
    send_tick(mk_tick(0, 1, 1, 0, 24'h000000, 5'd0, 0, 3'd0, 4'd0));
    send_tick(mk_tick(0, 1, 1, 0, 24'h000000, 5'd31, 0, 3'd0, 4'd0));
    send_tick(mk_tick(0, 1, 1, 0, 24'h000000, 5'd17, 1, 3'd6, 4'd2));
    // Stopped: neither clock source advances, but a reset still does.
    send_tick(mk_tick(1, 1, 1, 0, 24'hFFFFFF, 5'd16, 0, 3'd0, 4'd0));
    send_tick(mk_tick(0, 0, 0, 0, 24'hFFFFFF, 5'd16, 0, 3'd0, 4'd0));
    send_tick(mk_tick(0, 0, 0, 1, 24'hFFFFFF, 5'd16, 0, 3'd0, 4'd0));
    // Restart and advance on the same tick.
    send_tick(mk_tick(1, 1, 1, 0, 24'h000000, 5'd16, 0, 3'd0, 4'd0));
    send_tick(mk_tick(0, 1, 1, 0, 24'h000000, 5'd16, 0, 3'd0, 4'd0));
    // Reset together with an external or a phase advance ends at step 0.
    send_tick(mk_tick(0, 1, 1, 1, 24'h000000, 5'd16, 1, 3'd1, 4'd0));
    send_tick(mk_tick(0, 0, 0, 0, 24'hFFFFFF, 5'd16, 0, 3'd0, 4'd0));
    send_tick(mk_tick(0, 0, 0, 1, 24'hFFFFFF, 5'd16, 0, 3'd0, 4'd0));
    // Stop and reset on one tick, then resume.
    send_tick(mk_tick(1, 0, 0, 1, 24'h123456, 5'd8, 1, 3'd0, 4'd0));
    send_tick(mk_tick(1, 0, 0, 0, 24'hABCDEF, 5'd8, 0, 3'd0, 4'd0));

    // Random ticks under four idling patterns.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct = 83;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct <= 83;
        end
        default: begin
          send_idle_pct = 6;
          recv_stall_pct <= 6;
        end
      endcase
      for (int i = 0; i < 180; i++) send_tick(random_tick());
    end

    // Long receiver hold-off while ticks keep coming, so the input backs up.
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    hold_req <= ~hold_req;
    for (int i = 0; i < 40; i++) send_tick(random_tick());
    in_valid <= 1'b0;

    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d ticks, checked %0d results: %0d advances, %0d resets, %0d stopped ticks.",
             items_sent, sb.checked, sb.advances, sb.resets, sb.stopped_ticks);
    $display("Input was held off for %0d cycles under receiver back-pressure.", in_stalls);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
